[rtl/core/mdcb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mdcb_pkg;

  // Filter and scaling shifts
  localparam int unsigned DC_SHIFT  = 12;
  localparam int unsigned PCM_SHIFT = 12;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned PCM_W  = 16;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic REG_STEREO_FRAMES = 1'b0;
  localparam logic REG_RIGHT_SLOT    = 1'b1;

  localparam logic signed [WORD_W-1:0] PCM_MAX = 32'sd32767;
  localparam logic signed [WORD_W-1:0] PCM_MIN = -32'sd32768;

endpackage

`default_nettype wire

[rtl/core/mic_slot_dc_block_to_pcm16_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Two register stages: stage 1 (sample_r) holds the accepted word, stage 2 (pcm_r) the result.
// Throughput: one word per cycle while out_tready is high; the DC level update is one
//   subtract, shift and add in the result stage; the level loop closes through dc_level_r.
// Reset (rst_n low, synchronous): both stages empty, DC level unprimed and zero,
//   stereo_frames and right_slot cleared.
module mic_slot_dc_block_to_pcm16_unit
  import mdcb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] left_word, [63:32] right_word
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] pcm_sample
  output logic [0:0]       out_tuser,  // [0] clipped
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // ---------------------------------------------------------------- config
  logic stereo_frames_r;
  logic right_slot_r;
  logic cfg_wr;
  logic cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_frames_r <= 1'b0;
      right_slot_r    <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STEREO_FRAMES: stereo_frames_r <= cfg_pwdata[0];
        REG_RIGHT_SLOT:    right_slot_r    <= cfg_pwdata[0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STEREO_FRAMES: cfg_prdata = {31'd0, stereo_frames_r};
      REG_RIGHT_SLOT:    cfg_prdata = {31'd0, right_slot_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  // Stage 1 holds the selected sample; stage 2 is the result register. Stage 1
  // drains whenever the result register is empty or being taken.
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_go;
  logic in_acc;

  assign s1_go     = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | s1_go;
  assign in_acc    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s1_go)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic signed [WORD_W-1:0] sample_r;
  logic signed [WORD_W-1:0] sample_nxt;

  // mono mode always takes the left word
  assign sample_nxt = (stereo_frames_r & right_slot_r) ? $signed(in_tdata[63:32])
                                                       : $signed(in_tdata[31:0]);

  always_ff @(posedge clk) begin
    if (in_acc) sample_r <= sample_nxt;
  end

  // ---------------------------------------------------------------- stage 2
  logic                     dc_primed_r;
  logic signed [WORD_W-1:0] dc_level_r;
  logic signed [WORD_W-1:0] dc_base;
  logic signed [WORD_W:0]   dc_diff;
  logic signed [WORD_W:0]   dc_step;
  logic signed [WORD_W-1:0] dc_level_nxt;
  logic signed [WORD_W:0]   centered;
  logic signed [WORD_W-1:0] centered_sat;
  logic signed [WORD_W-1:0] scaled;
  logic [PCM_W-1:0]         pcm_nxt;
  logic                     clip_nxt;
  logic [PCM_W-1:0]         pcm_r;
  logic                     clip_r;

  // first sample loads the level, so its own step is zero
  assign dc_base      = dc_primed_r ? dc_level_r : sample_r;
  assign dc_diff      = {sample_r[WORD_W-1], sample_r} - {dc_base[WORD_W-1], dc_base};
  assign dc_step      = dc_diff >>> DC_SHIFT;
  // level stays between seen samples, so the sum fits 32 bits
  assign dc_level_nxt = dc_base + dc_step[WORD_W-1:0];

  assign centered = {sample_r[WORD_W-1], sample_r} - {dc_level_nxt[WORD_W-1], dc_level_nxt};

  always_comb begin
    if (centered[WORD_W] != centered[WORD_W-1])
      centered_sat = centered[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}}
                                      : {1'b0, {(WORD_W-1){1'b1}}};
    else
      centered_sat = centered[WORD_W-1:0];
  end

  assign scaled = centered_sat >>> PCM_SHIFT;

  always_comb begin
    if (scaled > PCM_MAX) begin
      pcm_nxt  = PCM_MAX[PCM_W-1:0];
      clip_nxt = 1'b1;
    end else if (scaled < PCM_MIN) begin
      pcm_nxt  = PCM_MIN[PCM_W-1:0];
      clip_nxt = 1'b1;
    end else begin
      pcm_nxt  = scaled[PCM_W-1:0];
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_primed_r <= 1'b0;
      dc_level_r  <= '0;
    end else if (s1_go) begin
      dc_primed_r <= 1'b1;
      dc_level_r  <= dc_level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      pcm_r  <= pcm_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = pcm_r;
  assign out_tuser[0] = clip_r;

  // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
  // a clip flag only ever comes with a full-scale sample
  a_clip_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && clip_r) |-> (pcm_r == 16'h7fff || pcm_r == 16'h8000))
    else $error("clipped word without full-scale pcm value");

  // the word that primes the level comes out as silence
  a_prime_silent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(dc_primed_r) |-> (pcm_r == '0 && !clip_r && out_valid_r))
    else $error("priming word not zero");

  // no result can exist before the level has been primed
  a_primed_before_out: assert property (@(posedge clk) disable iff (!rst_n)
    !dc_primed_r |-> !out_valid_r)
    else $error("result present with unprimed level");
`endif

endmodule

`default_nettype wire
